FILE: sv/fwa_pkg.sv
// Package for the fixed-width integer ALU: operation codes and shared types.
// No dependencies.
`default_nettype none
package fwa_pkg;
	typedef enum logic [1:0] {
		OP_ADD = 2'd0,
		OP_SUB = 2'd1,
		OP_MUL = 2'd2,
		OP_DIV = 2'd3
	} op_t;
	localparam int unsigned MAX_W = 64;
	// Quotient bits resolved per divider pipeline stage.
	localparam int unsigned DIV_STEPS = 4;
endpackage
`default_nettype wire

FILE: sv/fwa_div_stage.sv
// One stage of the restoring divider: STEPS quotient bits per stage.
// Depends on nothing but its parameters.
`default_nettype none
module fwa_div_stage #(
	parameter int unsigned W     = 64,
	parameter int unsigned STEPS = 8
) (
	input  wire logic [W-1:0] b,
	input  wire logic [W:0]   rem_in,
	input  wire logic [W-1:0] a_in,
	input  wire logic [W-1:0] q_in,
	output logic      [W:0]   rem_out,
	output logic      [W-1:0] a_out,
	output logic      [W-1:0] q_out
);
	always_comb begin
		logic [W:0]   r;
		logic [W-1:0] a;
		logic [W-1:0] q;
		logic [W+1:0] t;
		r = rem_in;
		a = a_in;
		q = q_in;
		for (int i = 0; i < STEPS; i++) begin
			t = {r, a[W-1]};
			a = {a[W-2:0], 1'b0};
			if (t >= {2'b00, b}) begin
				t = t - {2'b00, b};
				q = {q[W-2:0], 1'b1};
			end else begin
				q = {q[W-2:0], 1'b0};
			end
			r = t[W:0];
		end
		rem_out = r;
		a_out   = a;
		q_out   = q;
	end
endmodule
`default_nettype wire

FILE: sv/fixed_width_int_alu_core.sv
// Top level of the fixed-width integer ALU: pipelined add, subtract,
// multiply and restoring divide. Depends on fwa_pkg and fwa_div_stage.
//
//  channel | signals                              | handshake
//  --------+--------------------------------------+-------------------------
//  command | start, busy, kind, operand_a/b       | taken when start & !busy
//  result  | done, result_value                   | one-cycle strobe, no stall
//
// The pipeline has one input stage, ceil(WIDTH/4) divider stages of four quotient
// bits each, and one output stage. One item enters every cycle; busy stays low
// since the receiver never stalls. Reset clears the valid bits and done only;
// payload registers carry no reset.
// Multiply uses three 32x32 partial products in the first stage, summed next;
// the high-by-high product lies wholly above bit 63 and is dropped.
`default_nettype none
module fixed_width_int_alu_core #(
	parameter int unsigned WIDTH = 64
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	output logic             busy,
	input  wire logic [1:0]  kind,
	input  wire logic [63:0] operand_a,
	input  wire logic [63:0] operand_b,
	output logic             done,
	output logic [63:0]      result_value
);
	localparam int unsigned STEPS = fwa_pkg::DIV_STEPS;
	localparam int unsigned NST   = (WIDTH + STEPS - 1) / STEPS;
	localparam int unsigned DW    = NST * STEPS;  // divider width, padded

	assign busy = 1'b0;

	logic [63:0] mask;
	assign mask = (WIDTH >= 64) ? {64{1'b1}} : ((64'd1 << WIDTH) - 64'd1);

	// Stage 1: register operands, add/sub result and multiply partials.
	logic             v_s1;
	fwa_pkg::op_t     op_s1;
	logic [63:0]      as_s1;
	logic [DW-1:0]    a_s1;
	logic [DW-1:0]    b_s1;
	logic [63:0]      ll_s1, lh_s1, hl_s1;
	logic [63:0]      a_m, b_m;
	assign a_m = operand_a & mask;
	assign b_m = operand_b & mask;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s1 <= 1'b0;
		else         v_s1 <= start;
	end
	always_ff @(posedge clk) begin
		op_s1 <= fwa_pkg::op_t'(kind);
		as_s1 <= (kind == fwa_pkg::OP_SUB) ? (a_m + (~b_m & mask) + 64'd1) : (a_m + b_m);
		a_s1  <= DW'(a_m);
		b_s1  <= DW'(b_m);
		ll_s1 <= {32'd0, a_m[31:0]} * {32'd0, b_m[31:0]};
		lh_s1 <= {32'd0, a_m[31:0]} * {32'd0, b_m[63:32]};
		hl_s1 <= {32'd0, a_m[63:32]} * {32'd0, b_m[31:0]};
	end

	// Divider pipeline; the non-divide result rides alongside.
	// The dividend enters zero-extended, so leading zero bits go through first.
	logic             v_p   [NST+1];
	fwa_pkg::op_t     op_p  [NST+1];
	logic [63:0]      oth_p [NST+1];
	logic [DW-1:0]    b_p   [NST+1];
	logic [DW:0]      r_p   [NST+1];
	logic [DW-1:0]    a_p   [NST+1];
	logic [DW-1:0]    q_p   [NST+1];

	assign v_p[0]   = v_s1;
	assign op_p[0]  = op_s1;
	assign oth_p[0] = (op_s1 == fwa_pkg::OP_MUL) ?
		(ll_s1 + {lh_s1[31:0], 32'd0} + {hl_s1[31:0], 32'd0}) : as_s1;
	assign b_p[0]   = b_s1;
	assign r_p[0]   = '0;
	assign a_p[0]   = a_s1;
	assign q_p[0]   = '0;

	for (genvar g = 0; g < NST; g++) begin : g_div
		logic [DW:0]   r_n;
		logic [DW-1:0] a_n, q_n;
		fwa_div_stage #(.W(DW), .STEPS(STEPS)) u_stage (
			.b(b_p[g]), .rem_in(r_p[g]), .a_in(a_p[g]), .q_in(q_p[g]),
			.rem_out(r_n), .a_out(a_n), .q_out(q_n)
		);
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) v_p[g+1] <= 1'b0;
			else         v_p[g+1] <= v_p[g];
		end
		always_ff @(posedge clk) begin
			op_p[g+1]  <= op_p[g];
			oth_p[g+1] <= oth_p[g];
			b_p[g+1]   <= b_p[g];
			r_p[g+1]   <= r_n;
			a_p[g+1]   <= a_n;
			q_p[g+1]   <= q_n;
		end
	end

	// Output stage: pick the result and apply the divide-by-zero rule.
	logic [63:0] q64;
	assign q64 = 64'(q_p[NST]);
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) done <= 1'b0;
		else         done <= v_p[NST];
	end
	always_ff @(posedge clk) begin
		if (op_p[NST] == fwa_pkg::OP_DIV)
			result_value <= (b_p[NST] == '0) ? mask : (q64 & mask);
		else
			result_value <= oth_p[NST] & mask;
	end
endmodule
`default_nettype wire

FILE: sv/fwa_checker.sv
// Port-level checker for the fixed-width integer ALU, bound to the top level.
// Depends on fwa_pkg and the fixed_width_int_alu_core ports.
`default_nettype none
module fwa_checker #(
	parameter int unsigned WIDTH = 64
) (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        start,
	input wire logic        busy,
	input wire logic        done,
	input wire logic [63:0] result_value
);
	localparam int unsigned LAT =
		(WIDTH + fwa_pkg::DIV_STEPS - 1) / fwa_pkg::DIV_STEPS + 2;

	a_lat: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |-> ##LAT done) else $error("item lost");
	a_src: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, LAT)) else $error("result invented");
	a_nobusy: assert property (@(posedge clk) !busy) else $error("busy raised");
	a_wide: assert property (@(posedge clk) disable iff (!arst_n)
		done && WIDTH < 64 |-> (result_value >> WIDTH) == 64'd0)
		else $error("bits above width");
endmodule

bind fixed_width_int_alu_core fwa_checker #(.WIDTH(WIDTH)) u_fwa_checker (
	.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
	.done(done), .result_value(result_value)
);
`default_nettype wire

FILE: sim/fixed_width_int_alu_core_test.sv
// Self-checking testbench for fixed_width_int_alu_core: directed corner items, then
// random add/subtract/multiply/divide items under several sender idle patterns.
// Depends on fwa_pkg and the core RTL.
`timescale 1ns / 100ps
`default_nettype none

class alu_scoreboard;
	bit [63:0] pending[$];
	int unsigned fails;
	int unsigned checked;

	// Compute the expected result of one item at width w.
	function bit [63:0] alu_result(fwa_pkg::op_t op, bit [63:0] a, bit [63:0] b,
			int unsigned w);
		bit [63:0] m;
		bit [63:0] acc;
		bit [63:0] part;
		bit [64:0] rem;
		bit [63:0] quo;
		m = (w >= 64) ? {64{1'b1}} : ((64'd1 << w) - 64'd1);
		a &= m;
		b &= m;
		case (op)
			fwa_pkg::OP_ADD: return (a + b) & m;
			fwa_pkg::OP_SUB: return (a + (~b & m) + 64'd1) & m;
			fwa_pkg::OP_MUL: begin
				acc = '0;
				part = a;
				for (int i = 0; i < w; i++) begin
					if (b[i]) acc = (acc + part) & m;
					part = (part << 1) & m;
				end
				return acc;
			end
			default: begin
				if (b == 0) return m;
				rem = '0;
				quo = '0;
				for (int i = w - 1; i >= 0; i--) begin
					rem = {rem[63:0], a[i]};
					quo = quo << 1;
					if (rem >= {1'b0, b}) begin
						rem = rem - {1'b0, b};
						quo[0] = 1'b1;
					end
				end
				return quo & m;
			end
		endcase
	endfunction

	function void note_item(fwa_pkg::op_t op, bit [63:0] a, bit [63:0] b, int unsigned w);
		pending = {pending, alu_result(op, a, b, w)};
	endfunction

	function void check_result(bit [63:0] got);
		bit [63:0] want;
		if (pending.size() == 0) begin
			$display("%0t: result_value expected none actual %h", $time, got);
			fails++;
			return;
		end
		want = pending.pop_front();
		checked++;
		if (want !== got) begin
			$display("%0t: result_value expected %h actual %h", $time, want, got);
			fails++;
		end
	endfunction
endclass

module fixed_width_int_alu_core_test;
	localparam int unsigned WIDTH = 64;
	localparam int unsigned LATENCY =
		(WIDTH + fwa_pkg::DIV_STEPS - 1) / fwa_pkg::DIV_STEPS + 2;
	localparam int unsigned WATCHDOG = 2000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic [1:0] kind = '0;
	logic [63:0] operand_a = '0;
	logic [63:0] operand_b = '0;
	logic busy;
	logic done;
	logic [63:0] result_value;

	alu_scoreboard ledger = new();
	int unsigned idle_pct;
	int unsigned quiet_cycles;
	int unsigned items_sent;

	fixed_width_int_alu_core #(.WIDTH(WIDTH)) dut (.*);

	always #5 clk = ~clk;

	// Check results and count cycles with no traffic; strobes are sampled at the edge.
	always @(posedge clk) begin
		if (arst_n && done) ledger.check_result(result_value);
		if ((start && !busy) || done) quiet_cycles <= 0;
		else quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG) begin
			$display("fixed_width_int_alu_core: mismatch");
			$finish;
		end
	end

	function automatic bit [63:0] rand64();
		return {$urandom(), $urandom()};
	endfunction

	// Pick an operand biased toward corners: zero, one, all ones, sign bit, small values.
	function automatic bit [63:0] pick_operand();
		case ($urandom_range(9))
			0: return 64'd0;
			1: return 64'd1;
			2: return {64{1'b1}};
			3: return 64'h8000_0000_0000_0000;
			4: return 64'($urandom_range(255));
			5: return rand64() >> $urandom_range(63);
			default: return rand64();
		endcase
	endfunction

	// Idle with start low at random, then drive one item and hold it until accepted.
	task automatic send_item(fwa_pkg::op_t op, bit [63:0] a, bit [63:0] b);
		while ($urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start <= 1'b1;
		kind <= op;
		operand_a <= a;
		operand_b <= b;
		do @(posedge clk); while (busy);
		ledger.note_item(op, a, b, WIDTH);
		items_sent++;
	endtask

	task automatic drain();
		start <= 1'b0;
		while (ledger.pending.size() != 0) @(posedge clk);
		repeat (LATENCY) @(posedge clk);
	endtask

	initial begin
		fwa_pkg::op_t ops[4];
		ops = '{fwa_pkg::OP_ADD, fwa_pkg::OP_SUB, fwa_pkg::OP_MUL, fwa_pkg::OP_DIV};
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: every operation on corner operands, plus divide by zero.
		idle_pct = 0;
		foreach (ops[i]) begin
			send_item(ops[i], 64'd0, 64'd0);
			send_item(ops[i], {64{1'b1}}, {64{1'b1}});
			send_item(ops[i], 64'h8000_0000_0000_0000, 64'd1);
			send_item(ops[i], 64'h7fff_ffff_ffff_ffff, 64'd2);
			send_item(ops[i], 64'd12345, 64'd0);
		end
		send_item(fwa_pkg::OP_DIV, 64'd7, 64'h8000_0000_0000_0001);
		// Pause until everything has come back.
		drain();

		// Random phases: no idling, heavy idling, light idling, then no idling again.
		for (int ph = 0; ph < 4; ph++) begin
			idle_pct = (ph == 0) ? 0 : (ph == 1) ? 60 : (ph == 2) ? 11 : 0;
			repeat (100) send_item(fwa_pkg::op_t'($urandom_range(3)), pick_operand(),
				pick_operand());
			if (ph == 1) drain();
		end
		drain();

		$display("Sent %0d items over all four operations, checked %0d results.",
			items_sent, ledger.checked);
		if (ledger.fails == 0) begin
			$display("fixed_width_int_alu_core: match");
		end else begin
			$display("fixed_width_int_alu_core: mismatch");
		end
		$finish;
	end
endmodule
`default_nettype wire
